// ===== rtl/awbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbd_pkg: shared constants for the alpha-weighted box downscaler
// Pixel channel widths, the per-block quotient width and channel indexing.
// ----------------------------------------------------------------------------
package awbd_pkg;

   localparam int PIX_W  = 8;   // one RGBA channel
   localparam int QUO_W  = 8;   // a rounded mean colour never exceeds 255
   localparam int STEP_W = 3;   // indexes one quotient bit
   localparam int NUM_CH = 3;   // red, green, blue
   localparam int CH_W   = 2;   // indexes one colour channel

   localparam logic [CH_W-1:0] CH_RED  = 2'd0;
   localparam logic [CH_W-1:0] CH_BLUE = 2'd2;

endpackage

// ===== rtl/awbd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbd_div: iterative restoring divider
// Produces an 8-bit quotient, one bit per cycle, most significant bit first.
// The caller guarantees the quotient fits in 8 bits.
// ----------------------------------------------------------------------------
module awbd_div #(
   parameter int NUM_W = 22
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            numer,
   input  logic [NUM_W-1:0]            denom,
   output logic                        done,
   output logic [awbd_pkg::QUO_W-1:0]  quotient
);
   import awbd_pkg::*;

   localparam int EXT_W = NUM_W + QUO_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  den_ff, den_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [EXT_W-1:0]  shifted;
   logic [EXT_W-1:0]  rem_ext;

   always_comb begin
      shifted = EXT_W'(den_ff) << step_ff;
      rem_ext = EXT_W'(rem_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUO_W - 1);
         rem_in  = numer;
         den_in  = denom;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ext >= shifted) begin
            rem_in          = NUM_W'(rem_ext - shifted);
            quo_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         quo_ff  <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/alpha_weighted_box_downscale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_weighted_box_downscale: RGBA8 alpha-weighted box filter downsampler
// Accumulates colour*alpha and alpha over a square block, then emits the
// rounded weighted mean colours and the rounded mean alpha; factor 0 passes pixels through.
// ----------------------------------------------------------------------------
// Passthrough (factor 0): the pixel is registered at accept and copied to the result register in ST_FINISH.
// Accumulating: accept, then one shared 8x8 multiply-add per colour; a new request waits for ST_IDLE.
// The last request of a block then runs three divisions on the shared divider and loads
// the result register; a fully transparent block skips the divisions.
// A full result register holds the block in its last state until the result is taken.
// Synchronous reset clears the factor, the sums, the pixel count and the output valid.
module alpha_weighted_box_downscale #(
   parameter int MAX_FACTOR_LOG2 = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [1:0]                  csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [awbd_pkg::PIX_W-1:0]  req_red,
   input  logic [awbd_pkg::PIX_W-1:0]  req_green,
   input  logic [awbd_pkg::PIX_W-1:0]  req_blue,
   input  logic [awbd_pkg::PIX_W-1:0]  req_alpha,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [awbd_pkg::PIX_W-1:0]  rsp_out_red,
   output logic [awbd_pkg::PIX_W-1:0]  rsp_out_green,
   output logic [awbd_pkg::PIX_W-1:0]  rsp_out_blue,
   output logic [awbd_pkg::PIX_W-1:0]  rsp_out_alpha
);
   import awbd_pkg::*;

   localparam int CNT_W  = 2 * MAX_FACTOR_LOG2 + 1;
   localparam int WSUM_W = 2 * PIX_W + 2 * MAX_FACTOR_LOG2;
   localparam int ASUM_W = PIX_W + 2 * MAX_FACTOR_LOG2;
   localparam int NUM_W  = WSUM_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        factor_ff, factor_in;
   logic [WSUM_W-1:0] wsum_ff [NUM_CH];
   logic [WSUM_W-1:0] wsum_in [NUM_CH];
   logic [ASUM_W-1:0] asum_ff, asum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CH_W-1:0]   chan_ff, chan_in;
   logic              pass_ff, pass_in;
   logic [PIX_W-1:0]  pix_ff [NUM_CH];
   logic [PIX_W-1:0]  pix_in [NUM_CH];
   logic [PIX_W-1:0]  alpha_ff, alpha_in;
   logic [QUO_W-1:0]  res_ff [NUM_CH];
   logic [QUO_W-1:0]  res_in [NUM_CH];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_ff [NUM_CH];
   logic [PIX_W-1:0]  rsp_in [NUM_CH];
   logic [PIX_W-1:0]  rsp_alpha_ff, rsp_alpha_in;

   logic [1:0]        k_eff;
   logic [2:0]        shamt;
   logic [CNT_W-1:0]  block_n;
   logic [2*PIX_W-1:0] product;
   logic [ASUM_W:0]   alpha_rnd;
   logic [PIX_W-1:0]  alpha_mean;
   logic              div_start;
   logic              div_done;
   logic [QUO_W-1:0]  div_quo;
   logic [NUM_W-1:0]  div_numer;
   logic [NUM_W-1:0]  div_denom;
   logic              out_free;

   // factor values above the maximum saturate
   assign k_eff   = (factor_ff > 2'(MAX_FACTOR_LOG2)) ? 2'(MAX_FACTOR_LOG2) : factor_ff;
   assign shamt   = {k_eff, 1'b0};
   assign block_n = CNT_W'(1) << shamt;

   // shared multiplier: one colour channel per cycle
   assign product = pix_ff[chan_ff] * alpha_ff;

   // round(sum / N) with N a power of four: add N/2, shift
   assign alpha_rnd  = (ASUM_W+1)'(asum_ff) + ((ASUM_W+1)'(block_n) >> 1);
   assign alpha_mean = PIX_W'(alpha_rnd >> shamt);

   // round(w / a) = (2w + a) / (2a)
   assign div_numer = NUM_W'({wsum_ff[chan_ff], 1'b0}) + NUM_W'(asum_ff);
   assign div_denom = NUM_W'({asum_ff, 1'b0});

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   awbd_div #(
      .NUM_W(NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      factor_in    = factor_ff;
      wsum_in      = wsum_ff;
      asum_in      = asum_ff;
      count_in     = count_ff;
      chan_in      = chan_ff;
      pass_in      = pass_ff;
      pix_in       = pix_ff;
      alpha_in     = alpha_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rsp_alpha_in = rsp_alpha_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pix_in[0] = req_red;
               pix_in[1] = req_green;
               pix_in[2] = req_blue;
               alpha_in  = req_alpha;
               chan_in   = CH_RED;
               if (k_eff == 2'd0) begin
                  pass_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  pass_in  = 1'b0;
                  asum_in  = asum_ff + ASUM_W'(req_alpha);
                  count_in = count_ff + 1'b1;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            wsum_in[chan_ff] = wsum_ff[chan_ff] + WSUM_W'(product);
            if (chan_ff == CH_BLUE) begin
               chan_in  = CH_RED;
               state_in = (count_ff == block_n) ? ST_DIV_START : ST_IDLE;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end
         ST_DIV_START: begin
            if (asum_ff == '0) begin
               // fully transparent block: colours are zero
               res_in[chan_ff] = '0;
               if (chan_ff == CH_BLUE) begin
                  state_in = ST_FINISH;
               end else begin
                  chan_in = chan_ff + 1'b1;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_in[chan_ff] = div_quo;
               if (chan_ff == CH_BLUE) begin
                  state_in = ST_FINISH;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pass_ff) begin
                  rsp_in       = pix_ff;
                  rsp_alpha_in = alpha_ff;
               end else begin
                  rsp_in       = res_ff;
                  rsp_alpha_in = alpha_mean;
                  for (int i = 0; i < NUM_CH; i++) begin
                     wsum_in[i] = '0;
                  end
                  asum_in  = '0;
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a factor write drops any partial block
      if (csr_write_en) begin
         factor_in = csr_write_data;
         for (int i = 0; i < NUM_CH; i++) begin
            wsum_in[i] = '0;
         end
         asum_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         factor_ff    <= '0;
         for (int i = 0; i < NUM_CH; i++) begin
            wsum_ff[i] <= '0;
         end
         asum_ff      <= '0;
         count_ff     <= '0;
         chan_ff      <= CH_RED;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         wsum_ff      <= wsum_in;
         asum_ff      <= asum_in;
         count_ff     <= count_in;
         chan_ff      <= chan_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         pix_ff       <= pix_in;
         alpha_ff     <= alpha_in;
         res_ff       <= res_in;
         rsp_ff       <= rsp_in;
         rsp_alpha_ff <= rsp_alpha_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_ff[0];
   assign rsp_out_green = rsp_ff[1];
   assign rsp_out_blue  = rsp_ff[2];
   assign rsp_out_alpha = rsp_alpha_ff;

endmodule
